@@ src/aifp_pkg.sv @@
// Shared types and constants for the ASCII integer field parser.
package aifp_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_CONVERSION  = 2'd0;
	localparam logic [1:0] REG_TARGET_SIZE = 2'd1;
	localparam logic [1:0] REG_MAX_CHARS   = 2'd2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 7;

	// Conversion codes.
	localparam logic [2:0] CONV_SDEC = 3'd0;
	localparam logic [2:0] CONV_AUTO = 3'd1;
	localparam logic [2:0] CONV_UDEC = 3'd2;
	localparam logic [2:0] CONV_OCT  = 3'd3;
	localparam logic [2:0] CONV_HEX  = 3'd4;

	// Target size codes.
	localparam logic [1:0] TS_8  = 2'd0;
	localparam logic [1:0] TS_16 = 2'd1;
	localparam logic [1:0] TS_32 = 2'd2;
	localparam logic [1:0] TS_64 = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_DIGITS = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_END       = 2'd3;

	// Depth of the queue between the classifier and the sequencer.
	localparam int QUEUE_DEPTH = 2;

	// One classified character as it travels through the queue.
	typedef struct packed {
		logic       at_end;
		logic       is_space;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       hex_ok;
		logic [3:0] digit;
	} cls_t;

	// Request from the sequencer to the result formatter when a field ends or the input ends.
	typedef struct packed {
		logic        is_end;
		logic        taken;
		logic [6:0]  used;
		logic [63:0] acc;
		logic        ovf;
		logic        neg;
		logic        dig;
	} fin_req_t;

endpackage

@@ src/aifp_item_if.sv @@
// Input channel carrying one character or an end-of-input mark.
interface aifp_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source(output valid, ch, at_end, input ready);
	modport sink(input valid, ch, at_end, output ready);
endinterface

@@ src/aifp_result_if.sv @@
// Result channel carrying one parsed field.
interface aifp_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;
	logic        char_taken;
	logic [6:0]  chars_used;

	modport source(output valid, value, status, char_taken, chars_used, input ready);
	modport sink(input valid, value, status, char_taken, chars_used, output ready);
endinterface

@@ src/aifp_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface aifp_cfg_if import aifp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

@@ src/aifp_front.sv @@
// Front end: accepts characters and classifies them for the sequencer.
module aifp_front import aifp_pkg::*; (
	aifp_item_if.sink item,
	output logic      push_valid,
	input  logic      push_ready,
	output cls_t      push_data
);

	logic [7:0] c;

	assign c = item.ch;

	// Character classes and hex digit value.
	always_comb begin
		push_data          = '0;
		push_data.at_end   = item.at_end;
		push_data.is_space = !item.at_end && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
		push_data.is_plus  = !item.at_end && c == 8'h2B;
		push_data.is_minus = !item.at_end && c == 8'h2D;
		push_data.is_zero  = !item.at_end && c == 8'h30;
		push_data.is_x     = !item.at_end && (c == 8'h78 || c == 8'h58);
		if (c >= 8'h30 && c <= 8'h39) begin
			push_data.hex_ok = !item.at_end;
			push_data.digit  = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			push_data.hex_ok = !item.at_end;
			push_data.digit  = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			push_data.hex_ok = !item.at_end;
			push_data.digit  = 4'(c - 8'h37);
		end
	end

	// The item channel is ready whenever the queue has room.
	assign push_valid = item.valid;
	assign item.ready = push_ready;

endmodule

@@ src/aifp_queue.sv @@
// Small queue of classified characters between front and back.
module aifp_queue import aifp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cls_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cls_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - CW'(1))
		else $error("queue count did not drop after a lone pop");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not rise after a lone push");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers differ while empty");

endmodule

@@ src/aifp_back.sv @@
// Back end: per-character parsing sequencer and digit accumulator.
module aifp_back import aifp_pkg::*; #(
	parameter int MAX_TEXT = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_ready,
	input  cls_t       q_data,
	input  logic [2:0] conversion,
	input  logic [6:0] max_chars,
	output logic       fin_valid,
	input  logic       fin_ready,
	output fin_req_t   fin_data
);

	localparam int TW = $clog2(MAX_TEXT + 1);

	typedef enum logic [2:0] {PH_SKIP, PH_SIGN, PH_ZERO, PH_X, PH_DIGITS} phase_t;
	typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX, BASE_AUTO} base_t;

	phase_t        phase_q, ph_d;
	base_t         base_q, base_d, base_init;
	logic [63:0]   acc_q, acc_d, acc_src;
	logic          ovf_q, ovf_d, ovf_src;
	logic          neg_q, neg_d;
	logic          dig_q, dig_d;
	logic [TW-1:0] len_q, len_d, limit;
	logic [7:0]    limit_wide;
	logic          fin_valid_s1;
	fin_req_t      fin_s1, fin_d;
	logic          adv, pop, emit, emit_end, taken, done, dvalid;
	logic [67:0]   mac_hex, mac_oct, mac_dec, mac;

	// Field character limit.
	assign limit_wide = (max_chars != 7'd0 && {1'b0, max_chars} <= 8'(MAX_TEXT)) ?
		{1'b0, max_chars} : 8'(MAX_TEXT);
	assign limit = limit_wide[TW-1:0];

	always_comb begin
		case (conversion)
			CONV_OCT:  base_init = BASE_OCT;
			CONV_HEX:  base_init = BASE_HEX;
			CONV_AUTO: base_init = BASE_AUTO;
			default:   base_init = BASE_DEC;
		endcase
	end

	// Multiply-add candidates; a new field starts from a cleared accumulator.
	assign acc_src = (phase_q == PH_SKIP) ? 64'd0 : acc_q;
	assign ovf_src = (phase_q == PH_SKIP) ? 1'b0 : ovf_q;
	assign mac_hex = ({4'd0, acc_src} << 4) + {64'd0, q_data.digit};
	assign mac_oct = ({4'd0, acc_src} << 3) + {64'd0, q_data.digit};
	assign mac_dec = ({4'd0, acc_src} << 3) + ({4'd0, acc_src} << 1) + {64'd0, q_data.digit};

	// Stage handshake: the sequencer moves only if the request register can take a result.
	assign adv     = !fin_valid_s1 || fin_ready;
	assign q_ready = adv;
	assign pop     = q_valid && adv;

	// One character step through the phases.
	always_comb begin
		ph_d     = phase_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		neg_d    = neg_q;
		len_d    = len_q;
		dig_d    = dig_q;
		base_d   = base_q;
		emit     = 1'b0;
		emit_end = 1'b0;
		taken    = 1'b0;
		done     = 1'b0;
		dvalid   = 1'b0;
		mac      = mac_dec;

		if (ph_d == PH_SKIP) begin
			done = 1'b1;
			if (q_data.at_end) begin
				emit     = 1'b1;
				emit_end = 1'b1;
			end else if (!q_data.is_space) begin
				acc_d  = 64'd0;
				ovf_d  = 1'b0;
				neg_d  = 1'b0;
				len_d  = '0;
				dig_d  = 1'b0;
				base_d = base_init;
				ph_d   = PH_SIGN;
				if (q_data.is_plus || q_data.is_minus) begin
					neg_d = q_data.is_minus;
					len_d = TW'(1);
					if (len_d >= limit) begin
						emit  = 1'b1;
						taken = 1'b1;
					end
				end else begin
					done = 1'b0;
				end
			end
		end

		// Possible leading zero of a prefix.
		if (!done && ph_d == PH_SIGN) begin
			if ((base_d == BASE_HEX || base_d == BASE_AUTO) && q_data.is_zero) begin
				done  = 1'b1;
				len_d = len_d + TW'(1);
				dig_d = 1'b1;
				acc_d = 64'd0;
				if (len_d >= limit) begin
					if (base_d == BASE_AUTO) begin
						base_d = BASE_OCT;
					end
					emit  = 1'b1;
					taken = 1'b1;
				end else begin
					ph_d = PH_ZERO;
				end
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_DEC;
				end
				ph_d = PH_DIGITS;
			end
		end

		// Possible x of a hex prefix.
		if (!done && ph_d == PH_ZERO) begin
			if (q_data.is_x) begin
				done   = 1'b1;
				len_d  = len_d + TW'(1);
				base_d = BASE_HEX;
				if (len_d >= limit) begin
					emit  = 1'b1;
					taken = 1'b1;
				end else begin
					ph_d = PH_X;
				end
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_OCT;
				end
				ph_d = PH_DIGITS;
			end
		end

		// After a 0x prefix, a character that is not a hex digit ends the field with the prefix as zero.
		if (!done && ph_d == PH_X) begin
			if (!q_data.hex_ok) begin
				done = 1'b1;
				emit = 1'b1;
			end else begin
				ph_d = PH_DIGITS;
			end
		end

		// Digit accumulation.
		if (!done) begin
			case (base_d)
				BASE_HEX: begin
					dvalid = q_data.hex_ok;
					mac    = mac_hex;
				end
				BASE_OCT: begin
					dvalid = q_data.hex_ok && q_data.digit <= 4'd7;
					mac    = mac_oct;
				end
				default: begin
					dvalid = q_data.hex_ok && q_data.digit <= 4'd9;
					mac    = mac_dec;
				end
			endcase
			if (!dvalid) begin
				emit = 1'b1;
			end else begin
				if (!ovf_src) begin
					if (mac[67:64] != 4'd0) begin
						ovf_d = 1'b1;
					end else begin
						acc_d = mac[63:0];
					end
				end
				dig_d = 1'b1;
				len_d = len_d + TW'(1);
				if (len_d >= limit) begin
					emit  = 1'b1;
					taken = 1'b1;
				end
			end
		end

		if (emit) begin
			ph_d = PH_SKIP;
		end

		fin_d        = '0;
		fin_d.is_end = emit_end;
		fin_d.taken  = taken;
		fin_d.used   = emit_end ? 7'd0 : 7'(len_d);
		fin_d.acc    = acc_d;
		fin_d.ovf    = ovf_d;
		fin_d.neg    = neg_d;
		fin_d.dig    = dig_d;
	end

	// Parser state and the finish request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SKIP;
			acc_q        <= 64'd0;
			ovf_q        <= 1'b0;
			neg_q        <= 1'b0;
			len_q        <= '0;
			dig_q        <= 1'b0;
			base_q       <= BASE_DEC;
			fin_valid_s1 <= 1'b0;
			fin_s1       <= '0;
		end else begin
			if (pop) begin
				phase_q <= ph_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
				neg_q   <= neg_d;
				len_q   <= len_d;
				dig_q   <= dig_d;
				base_q  <= base_d;
			end
			if (adv) begin
				fin_valid_s1 <= pop && emit;
			end
			if (pop && emit) begin
				fin_s1 <= fin_d;
			end
		end
	end

	assign fin_valid = fin_valid_s1;
	assign fin_data  = fin_s1;

	a_emit_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> phase_q == PH_SKIP)
		else $error("sequencer did not return to whitespace skip after a result");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid_s1 && !fin_ready) |=> fin_valid_s1 && $stable(fin_s1))
		else $error("finish request changed while stalled");
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_SKIP) |-> len_q < limit)
		else $error("field length reached the limit without a result");

endmodule

@@ src/aifp_finish.sv @@
// Result formatter: range check, sign handling and the output register.
module aifp_finish import aifp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] conversion,
	input  logic [1:0] target_size,
	input  logic       fin_valid,
	output logic       fin_ready,
	input  fin_req_t   fin_data,
	aifp_result_if.source result
);

	logic        is_signed, out_adv;
	logic [63:0] high, half, neg_acc, val;
	logic [1:0]  st;
	logic        res_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;
	logic        taken_q;
	logic [6:0]  used_q;

	assign is_signed = !(conversion == CONV_UDEC || conversion == CONV_OCT ||
		conversion == CONV_HEX);

	// Range bounds for the target width.
	always_comb begin
		case (target_size)
			TS_8: begin
				high = 64'h0000_0000_0000_00FF;
				half = 64'h0000_0000_0000_0080;
			end
			TS_16: begin
				high = 64'h0000_0000_0000_FFFF;
				half = 64'h0000_0000_0000_8000;
			end
			TS_32: begin
				high = 64'h0000_0000_FFFF_FFFF;
				half = 64'h0000_0000_8000_0000;
			end
			default: begin
				high = 64'hFFFF_FFFF_FFFF_FFFF;
				half = 64'h8000_0000_0000_0000;
			end
		endcase
	end

	assign neg_acc = 64'd0 - fin_data.acc;

	// Status and value of the finished field.
	always_comb begin
		st  = ST_OK;
		val = 64'd0;
		if (fin_data.is_end) begin
			st = ST_END;
		end else if (!fin_data.dig) begin
			st = ST_NO_DIGITS;
		end else if (fin_data.ovf) begin
			st = ST_RANGE;
		end else if (is_signed) begin
			if (fin_data.neg ? fin_data.acc > half : fin_data.acc >= half) begin
				st = ST_RANGE;
			end else begin
				val = fin_data.neg ? neg_acc : fin_data.acc;
			end
		end else if (fin_data.acc > high) begin
			st = ST_RANGE;
		end else begin
			val = fin_data.neg ? (neg_acc & high) : fin_data.acc;
		end
	end

	assign out_adv   = !res_valid_q || result.ready;
	assign fin_ready = out_adv;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && fin_valid) begin
			value_q  <= val;
			status_q <= st;
			taken_q  <= fin_data.taken;
			used_q   <= fin_data.used;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.value      = value_q;
	assign result.status     = status_q;
	assign result.char_taken = taken_q;
	assign result.chars_used = used_q;

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q == ST_END) |-> (used_q == 7'd0 && !taken_q))
		else $error("end-of-input result carries consumed text");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q != ST_OK) |-> value_q == 64'd0)
		else $error("failed conversion carries a nonzero value");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid && out_adv) |=> res_valid_q)
		else $error("finish request was dropped");

endmodule

@@ src/ascii_integer_field_parser_core.sv @@
// A character passes through the queue, the finish request register and the output register
// before its result shows on the output.
// Throughput: one character per cycle while the result channel keeps up.
// The rate is set by the combinational multiply-add and limit compare in the sequencer.
// A two-entry queue and the output register let input and output stall independently.
// Reset clears the parser to whitespace skip, empties the queue and loads register defaults.
module ascii_integer_field_parser_core import aifp_pkg::*; #(
	parameter int MAX_TEXT = 127
) (
	input logic           clk,
	input logic           arst_n,
	aifp_item_if.sink     item,
	aifp_result_if.source result,
	aifp_cfg_if.sink      cfg
);

	logic [2:0] conversion_q;
	logic [1:0] target_size_q;
	logic [6:0] max_chars_q;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	cls_t       push_data, pop_data;
	logic       fin_valid, fin_ready;
	fin_req_t   fin_data;

	// Configuration registers take a transfer every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conversion_q  <= CONV_SDEC;
			target_size_q <= TS_32;
			max_chars_q   <= 7'd0;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_CONVERSION:  conversion_q  <= cfg.data[2:0];
				REG_TARGET_SIZE: target_size_q <= cfg.data[1:0];
				REG_MAX_CHARS:   max_chars_q   <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	aifp_front u_front (
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	aifp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	aifp_back #(.MAX_TEXT(MAX_TEXT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (pop_valid),
		.q_ready    (pop_ready),
		.q_data     (pop_data),
		.conversion (conversion_q),
		.max_chars  (max_chars_q),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.fin_data   (fin_data)
	);

	aifp_finish u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.conversion  (conversion_q),
		.target_size (target_size_q),
		.fin_valid   (fin_valid),
		.fin_ready   (fin_ready),
		.fin_data    (fin_data),
		.result      (result)
	);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ASCII integer field parser core.
module tb_top;
	import aifp_pkg::*;

	localparam int TEXT_LIMIT     = 127;
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 700;

	typedef enum logic [2:0] {PH_SKIP, PH_SIGN, PH_ZERO, PH_X, PH_DIGITS} parse_phase_e;
	typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX, RADIX_AUTO} radix_e;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic        char_taken;
		logic [6:0]  chars_used;
	} field_result_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} text_char_t;

	logic clk;
	logic arst_n;

	aifp_item_if   item_ch();
	aifp_result_if res_ch();
	aifp_cfg_if    cfg_ch();

	ascii_integer_field_parser_core #(
		.MAX_TEXT(TEXT_LIMIT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	// Parser state as the block should hold it.
	parse_phase_e ph       = PH_SKIP;
	logic [63:0]  acc      = '0;
	bit           ovf      = 1'b0;
	bit           neg      = 1'b0;
	bit           dig      = 1'b0;
	int           tlen     = 0;
	radix_e       radix    = RADIX_DEC;
	logic [2:0]   cfg_conv = CONV_SDEC;
	logic [1:0]   cfg_size = TS_32;
	logic [6:0]   cfg_maxc = '0;

	text_char_t    pending_chars[$];
	field_result_t expected_fields[$];
	text_char_t    next_char;
	field_result_t want;
	field_result_t pred;

	int  items_queued   = 0;
	int  items_accepted = 0;
	int  idle_cycles    = 0;
	int  err_count      = 0;
	int  settings_used  = 0;
	int  status_seen[4] = '{0, 0, 0, 0};
	int  hold_at        = 32'h7fff_ffff;
	int  hold_left      = 0;
	bit  hold_done      = 1'b0;
	bit  idle_on        = 1'b1;
	bit  item_went      = 1'b0;
	bit  moved;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// Close the current field and form its result; the parser goes back to skipping.
	function automatic bit close_field(input bit taken, output field_result_t r);
		int          bits;
		logic [63:0] half;
		logic [63:0] high;
		bits = 8 << cfg_size;
		r.value      = '0;
		r.char_taken = taken;
		r.chars_used = tlen[6:0];
		ph = PH_SKIP;
		if (!dig) begin
			r.status = ST_NO_DIGITS;
		end else if (ovf) begin
			r.status = ST_RANGE;
		end else if (!(cfg_conv inside {CONV_UDEC, CONV_OCT, CONV_HEX})) begin
			half = 64'd1 << (bits - 1);
			if (neg ? (acc > half) : (acc > half - 64'd1)) begin
				r.status = ST_RANGE;
			end else begin
				r.status = ST_OK;
				r.value  = neg ? (64'd0 - acc) : acc;
			end
		end else begin
			high = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
			if (acc > high) begin
				r.status = ST_RANGE;
			end else begin
				r.status = ST_OK;
				r.value  = neg ? ((64'd0 - acc) & high) : acc;
			end
		end
		return 1'b1;
	endfunction

	// Advance the parser by one character; returns 1 when a field result is due.
	function automatic bit advance_parser(input logic [7:0] c, input logic e,
			output field_result_t r);
		int lim;
		int d;
		int base;
		lim = (cfg_maxc != 0) ? int'(cfg_maxc) : TEXT_LIMIT;
		r = '0;
		if (ph == PH_SKIP) begin
			if (e) begin
				r.status = ST_END;
				return 1'b1;
			end
			if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return 1'b0;
			acc  = '0;
			ovf  = 1'b0;
			neg  = 1'b0;
			tlen = 0;
			dig  = 1'b0;
			radix = (cfg_conv == CONV_OCT) ? RADIX_OCT :
				(cfg_conv == CONV_HEX) ? RADIX_HEX :
				(cfg_conv == CONV_AUTO) ? RADIX_AUTO : RADIX_DEC;
			ph = PH_SIGN;
			if (c == "+" || c == "-") begin
				neg  = (c == "-");
				tlen = 1;
				if (tlen >= lim) return close_field(1'b1, r);
				return 1'b0;
			end
		end
		// A leading zero may open a hex prefix or mark octal in auto base.
		if (ph == PH_SIGN) begin
			if ((radix == RADIX_HEX || radix == RADIX_AUTO) && !e && c == "0") begin
				tlen++;
				dig = 1'b1;
				acc = '0;
				if (tlen >= lim) begin
					if (radix == RADIX_AUTO) radix = RADIX_OCT;
					return close_field(1'b1, r);
				end
				ph = PH_ZERO;
				return 1'b0;
			end
			if (radix == RADIX_AUTO) radix = RADIX_DEC;
			ph = PH_DIGITS;
		end
		if (ph == PH_ZERO) begin
			if (!e && (c == "x" || c == "X")) begin
				tlen++;
				radix = RADIX_HEX;
				if (tlen >= lim) return close_field(1'b1, r);
				ph = PH_X;
				return 1'b0;
			end
			if (radix == RADIX_AUTO) radix = RADIX_OCT;
			ph = PH_DIGITS;
		end
		// After a bare prefix the field ends with value zero unless a hex digit follows.
		if (ph == PH_X) begin
			if (e || hex_digit(c) < 0) return close_field(1'b0, r);
			ph = PH_DIGITS;
		end
		if (e) return close_field(1'b0, r);
		d = hex_digit(c);
		case (radix)
			RADIX_HEX: begin
				base = 16;
			end
			RADIX_OCT: begin
				base = 8;
				if (d > 7) d = -1;
			end
			default: begin
				base = 10;
				if (d > 9) d = -1;
			end
		endcase
		if (d < 0) return close_field(1'b0, r);
		// Overflow is sticky; the magnitude freezes once it would pass 64 bits.
		if (!ovf) begin
			if (acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(base)) ovf = 1'b1;
			else acc = acc * 64'(base) + 64'(d);
		end
		dig = 1'b1;
		tlen++;
		if (tlen >= lim) return close_field(1'b1, r);
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
		err_count++;
	endtask

	// Character driver: offers the next pending character once the last one transferred.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_went) begin
			if (pending_chars.size() != 0 && !(idle_on && $urandom_range(0, 99) < 13)) begin
				next_char = pending_chars.pop_front();
				item_ch.valid  <= 1'b1;
				item_ch.ch     <= next_char.ch;
				item_ch.at_end <= next_char.at_end;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && items_accepted >= hold_at) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= !(idle_on && $urandom_range(0, 99) < 13);
		end
	end

	// Monitor: applies register writes, checks results, predicts from accepted characters.
	always @(posedge clk) begin
		if (arst_n) begin
			item_went = item_ch.valid && item_ch.ready;
			moved = item_went;
			if (cfg_ch.valid && cfg_ch.ready) begin
				moved = 1'b1;
				case (cfg_ch.addr)
					REG_CONVERSION:  cfg_conv = cfg_ch.data[2:0];
					REG_TARGET_SIZE: cfg_size = cfg_ch.data[1:0];
					REG_MAX_CHARS:   cfg_maxc = cfg_ch.data;
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				moved = 1'b1;
				if (expected_fields.size() == 0) begin
					flag_mismatch("result with none expected, value", res_ch.value, '0);
				end else begin
					want = expected_fields.pop_front();
					if (res_ch.value !== want.value)
						flag_mismatch("value", res_ch.value, want.value);
					if (res_ch.status !== want.status)
						flag_mismatch("status", 64'(res_ch.status), 64'(want.status));
					if (res_ch.char_taken !== want.char_taken)
						flag_mismatch("char_taken", 64'(res_ch.char_taken), 64'(want.char_taken));
					if (res_ch.chars_used !== want.chars_used)
						flag_mismatch("chars_used", 64'(res_ch.chars_used), 64'(want.chars_used));
					status_seen[want.status]++;
				end
			end
			if (item_went) begin
				items_accepted++;
				if (advance_parser(item_ch.ch, item_ch.at_end, pred))
					expected_fields.push_back(pred);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
		$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [7:0] blank_char(input int k);
		case (k)
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0B;
			3: return 8'h0C;
			4: return 8'h0D;
			default: return 8'h20;
		endcase
	endfunction

	// Digit of the given radix, now and then a stray hex digit that may end the field.
	function automatic logic [7:0] digit_char(input int rdx);
		int v;
		v = $urandom_range(0, rdx - 1);
		if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 15);
		if (v < 10) return 8'("0" + v);
		return ($urandom_range(0, 1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back('{ch: c, at_end: 1'b0});
		items_queued++;
	endtask

	task automatic push_end();
		pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), at_end: 1'b1});
		items_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endtask

	// One field of random content shaped for the conversion; n counts its items after the leading blanks.
	task automatic push_field(input logic [2:0] cv, output int n);
		string terms;
		int    r;
		int    ndig;
		int    rdx;
		terms = ",;.gz8:9";
		n = 0;
		repeat ($urandom_range(0, 2)) push_char(blank_char($urandom_range(0, 5)));
		if ($urandom_range(0, 99) < 8) begin
			push_char(8'($urandom_range(0, 255)));
			n = 1;
			return;
		end
		r = $urandom_range(0, 9);
		if (r < 3) push_char("-");
		else if (r < 5) push_char("+");
		if (r < 5) n++;
		rdx = (cv == CONV_OCT) ? 8 : (cv == CONV_HEX) ? 16 : 10;
		if (cv == CONV_HEX || cv == CONV_AUTO) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				push_char("0");
				push_char(r[0] ? "x" : "X");
				rdx = 16;
				n += 2;
			end else if (cv == CONV_AUTO && r < 6) begin
				push_char("0");
				rdx = 8;
				n++;
			end
		end
		r = $urandom_range(0, 99);
		ndig = (r < 10) ? $urandom_range(14, 24) : (r < 15) ? 0 : $urandom_range(1, 5);
		repeat (ndig) push_char(digit_char(rdx));
		n += ndig;
		r = $urandom_range(0, 99);
		if (r < 15) push_end();
		else if (r < 40) push_char(blank_char($urandom_range(0, 5)));
		else push_char(terms[$urandom_range(0, terms.len() - 1)]);
		n++;
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_config(input logic [2:0] cv, input logic [1:0] ts, input logic [6:0] mc);
		write_reg(REG_CONVERSION, {4'd0, cv});
		write_reg(REG_TARGET_SIZE, {5'd0, ts});
		write_reg(REG_MAX_CHARS, mc);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Wait until every character has transferred and every result has come back.
	task automatic wait_quiet();
		@(negedge clk);
		while (!(items_accepted == items_queued && expected_fields.size() == 0)) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Main sequence: directed fields, then random phases under changing settings.
	initial begin
		int         n;
		int         cap;
		int         p;
		logic [2:0] cv;
		logic [1:0] ts;
		logic [6:0] mc;
		arst_n         = 1'b0;
		item_ch.valid  = 1'b0;
		item_ch.ch     = '0;
		item_ch.at_end = 1'b0;
		res_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.addr    = '0;
		cfg_ch.data    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: end while skipping, sign only, most negative 32-bit value.
		@(posedge clk);
		push_end();
		push_text("-,");
		push_text("-2147483648");
		push_end();
		settings_used++;
		wait_quiet();

		// Hex at 64 bits: lone prefix, then a mixed-case prefixed number.
		set_config(CONV_HEX, TS_64, 7'd0);
		@(posedge clk);
		push_text("0xg");
		push_text("0XfF");
		push_end();
		wait_quiet();

		// Random phases run until the total item count reaches the target.
		p = 0;
		while (items_queued < RANDOM_ITEMS) begin
			cv = (p < 8) ? 3'(p) : 3'($urandom_range(0, 4));
			ts = (p < 8) ? 2'(p) : 2'($urandom_range(0, 3));
			case (p % 6)
				0: mc = 7'd0;
				1: mc = 7'd127;
				2: mc = 7'd1;
				3: mc = 7'($urandom_range(2, 6));
				4: mc = 7'($urandom_range(7, 30));
				default: mc = 7'($urandom_range(0, 127));
			endcase
			set_config(cv, ts, mc);
			@(posedge clk);
			// One phase runs with no idling at all; another holds the receiver off.
			idle_on = (p != 3);
			if (p == 5) hold_at = items_queued + 4;
			cap = (p == 3) ? 150 : 50;
			n = 0;
			while (n < cap) begin
				int k;
				push_field(cv, k);
				n += k;
			end
			push_end();
			wait_quiet();
			p++;
		end

		// Drain, then check that nothing is left outstanding.
		for (int k = 0; k < 400 && expected_fields.size() != 0; k++) @(negedge clk);
		repeat (6) @(negedge clk);
		if (expected_fields.size() != 0)
			flag_mismatch("results never delivered, count", 64'(expected_fields.size()), '0);
		$display("Run covered %0d characters under %0d register settings.",
			items_accepted, settings_used);
		$display("Fields: %0d ok, %0d without digits, %0d out of range, %0d at end of input.",
			status_seen[ST_OK], status_seen[ST_NO_DIGITS], status_seen[ST_RANGE],
			status_seen[ST_END]);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
